/* rtl/dsp_pkg.sv */
// Shared types and constants for the decimal string parser.
package dsp_pkg;

    localparam int MAG_OUT_W = 127;
    localparam int EXP_W     = 32;
    localparam int FRAC_W    = 8;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Largest exponent magnitude accepted while scanning; a positive
    // exponent of this size is still rejected at the end.
    localparam logic [35:0] EXP_LIMIT   = 36'h0_8000_0000;
    localparam logic [31:0] EXP_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [7:0]  FRAC_SAT    = 8'hFF;

    typedef enum logic [1:0] {
        PH_START,
        PH_WHOLE,
        PH_FRAC,
        PH_EXP
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NO_DIGITS = 3'd2,
        ST_EXP_SIGN  = 3'd3,
        ST_BAD_EXP   = 3'd4,
        ST_INVALID   = 3'd5,
        ST_TOO_LARGE = 3'd6
    } status_t;

    typedef struct packed {
        status_t                status;
        logic                   negative;
        logic [MAG_OUT_W-1:0]   magnitude;
        logic [FRAC_W-1:0]      fraction_count;
        logic signed [EXP_W-1:0] exponent_value;
    } result_t;

endpackage

/* rtl/dsp_core.sv */
// Parse state and per-character next-state and result logic.
module dsp_core #(
    parameter int VALUE_BITS = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         char_code,
    input  logic               last_char,
    input  logic               empty_string,
    output logic               produce,
    output dsp_pkg::result_t   result
);

    localparam int MAG_W = VALUE_BITS - 1;

    dsp_pkg::phase_t      phase_reg, phase_next;
    logic                 minus_reg, minus_next;
    logic [MAG_W-1:0]     value_reg, value_next;
    logic                 vovf_reg, vovf_next;
    logic                 whole_reg, whole_next;
    logic [7:0]           frac_reg, frac_next;
    logic                 eneg_reg, eneg_next;
    logic                 esign_reg, esign_next;
    logic                 edig_reg, edig_next;
    logic [31:0]          emag_reg, emag_next;
    dsp_pkg::status_t     err_reg, err_next;

    logic                 is_digit;
    logic [3:0]           digit;
    logic [MAG_W+3:0]     fold_prod;
    logic [35:0]          exp_prod;
    dsp_pkg::phase_t      ph;
    logic                 consumed;
    logic                 fold_en;
    dsp_pkg::status_t     fin_status;

    assign is_digit = (char_code >= dsp_pkg::CH_ZERO) && (char_code <= dsp_pkg::CH_NINE);
    assign digit    = char_code[3:0];

    // value * 10 + digit, with four guard bits to catch overflow.
    assign fold_prod = ({4'b0, value_reg} << 3) + ({4'b0, value_reg} << 1)
                       + (MAG_W+4)'(digit);
    assign exp_prod  = ({4'b0, emag_reg} << 3) + ({4'b0, emag_reg} << 1) + 36'(digit);

    assign produce = last_char || empty_string;

    always_comb
    begin
        phase_next = phase_reg;
        minus_next = minus_reg;
        value_next = value_reg;
        vovf_next  = vovf_reg;
        whole_next = whole_reg;
        frac_next  = frac_reg;
        eneg_next  = eneg_reg;
        esign_next = esign_reg;
        edig_next  = edig_reg;
        emag_next  = emag_reg;
        err_next   = err_reg;
        ph         = phase_reg;
        consumed   = 1'b0;
        fold_en    = 1'b0;

        if (err_reg == dsp_pkg::ST_OK)
        begin
            if (ph == dsp_pkg::PH_START)
            begin
                ph = dsp_pkg::PH_WHOLE;
                phase_next = dsp_pkg::PH_WHOLE;
                if (char_code == dsp_pkg::CH_MINUS)
                begin
                    minus_next = 1'b1;
                    consumed   = 1'b1;
                end
                else if (char_code == dsp_pkg::CH_PLUS)
                begin
                    consumed = 1'b1;
                end
            end
            if (!consumed)
            begin
                case (ph)
                    dsp_pkg::PH_WHOLE, dsp_pkg::PH_FRAC:
                    begin
                        if (is_digit)
                        begin
                            fold_en = 1'b1;
                            if (ph == dsp_pkg::PH_WHOLE)
                            begin
                                whole_next = 1'b1;
                            end
                            else if (frac_reg != dsp_pkg::FRAC_SAT)
                            begin
                                frac_next = frac_reg + 8'd1;
                            end
                        end
                        else if (ph == dsp_pkg::PH_WHOLE && char_code == dsp_pkg::CH_DOT)
                        begin
                            phase_next = dsp_pkg::PH_FRAC;
                        end
                        else if (!whole_reg && frac_reg == 8'd0)
                        begin
                            err_next = dsp_pkg::ST_NO_DIGITS;
                        end
                        else if (char_code == dsp_pkg::CH_E_LO ||
                                 char_code == dsp_pkg::CH_E_UP)
                        begin
                            phase_next = dsp_pkg::PH_EXP;
                        end
                        else
                        begin
                            err_next = dsp_pkg::ST_INVALID;
                        end
                    end
                    dsp_pkg::PH_EXP:
                    begin
                        if (is_digit)
                        begin
                            edig_next = 1'b1;
                            if (exp_prod > dsp_pkg::EXP_LIMIT)
                            begin
                                err_next = dsp_pkg::ST_BAD_EXP;
                            end
                            else
                            begin
                                emag_next = exp_prod[31:0];
                            end
                        end
                        else if (!esign_reg && !edig_reg &&
                                 (char_code == dsp_pkg::CH_PLUS ||
                                  char_code == dsp_pkg::CH_MINUS))
                        begin
                            esign_next = 1'b1;
                            eneg_next  = (char_code == dsp_pkg::CH_MINUS);
                        end
                        else
                        begin
                            err_next = dsp_pkg::ST_BAD_EXP;
                        end
                    end
                    default:
                    begin
                        phase_next = ph;
                    end
                endcase
            end
        end

        // Once the magnitude has overflowed it stays cleared.
        if (fold_en && !vovf_reg)
        begin
            if (fold_prod[MAG_W+3:MAG_W] != 4'd0)
            begin
                vovf_next  = 1'b1;
                value_next = '0;
            end
            else
            begin
                value_next = fold_prod[MAG_W-1:0];
            end
        end

        // Final status is taken from the state after this character.
        if (err_next != dsp_pkg::ST_OK)
        begin
            fin_status = err_next;
        end
        else if (phase_next == dsp_pkg::PH_EXP && !edig_next)
        begin
            fin_status = esign_next ? dsp_pkg::ST_EXP_SIGN : dsp_pkg::ST_BAD_EXP;
        end
        else if (phase_next == dsp_pkg::PH_EXP && !eneg_next &&
                 emag_next > dsp_pkg::EXP_POS_MAX)
        begin
            fin_status = dsp_pkg::ST_BAD_EXP;
        end
        else if (phase_next != dsp_pkg::PH_EXP && !whole_next && frac_next == 8'd0)
        begin
            fin_status = dsp_pkg::ST_NO_DIGITS;
        end
        else if (vovf_next)
        begin
            fin_status = dsp_pkg::ST_TOO_LARGE;
        end
        else
        begin
            fin_status = dsp_pkg::ST_OK;
        end

        result = '0;
        if (empty_string)
        begin
            result.status = dsp_pkg::ST_EMPTY;
        end
        else
        begin
            result.status = fin_status;
            if (fin_status == dsp_pkg::ST_OK)
            begin
                result.negative       = minus_next;
                result.magnitude      = dsp_pkg::MAG_OUT_W'(value_next);
                result.fraction_count = frac_next;
                result.exponent_value = eneg_next ? (32'd0 - emag_next) : emag_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dsp_pkg::PH_START;
            minus_reg <= 1'b0;
            value_reg <= '0;
            vovf_reg  <= 1'b0;
            whole_reg <= 1'b0;
            frac_reg  <= '0;
            eneg_reg  <= 1'b0;
            esign_reg <= 1'b0;
            edig_reg  <= 1'b0;
            emag_reg  <= '0;
            err_reg   <= dsp_pkg::ST_OK;
        end
        else if (step)
        begin
            if (produce)
            begin
                // A finished string returns the parser to its starting state.
                phase_reg <= dsp_pkg::PH_START;
                minus_reg <= 1'b0;
                value_reg <= '0;
                vovf_reg  <= 1'b0;
                whole_reg <= 1'b0;
                frac_reg  <= '0;
                eneg_reg  <= 1'b0;
                esign_reg <= 1'b0;
                edig_reg  <= 1'b0;
                emag_reg  <= '0;
                err_reg   <= dsp_pkg::ST_OK;
            end
            else
            begin
                phase_reg <= phase_next;
                minus_reg <= minus_next;
                value_reg <= value_next;
                vovf_reg  <= vovf_next;
                whole_reg <= whole_next;
                frac_reg  <= frac_next;
                eneg_reg  <= eneg_next;
                esign_reg <= esign_next;
                edig_reg  <= edig_next;
                emag_reg  <= emag_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule

/* rtl/decimal_string_parser.sv */
// Top level of the streaming decimal string parser.
//
//  Channel | Direction | Handshake                 | Word
//  --------+-----------+---------------------------+----------------------------------
//  char    | in        | char_valid / char_stall   | char_code, last_char, empty_string
//  result  | out       | result_valid / result_stall | status, negative, magnitude_high,
//          |           |                           | magnitude_low, fraction_count,
//          |           |                           | exponent_value
//
// One character word is taken per cycle while char_stall is low. A word is held in
// the input register, where the 127-bit multiply-by-ten-and-add sets the cycle time,
// and the result of a word that ends a string is then registered in the output register.
// Reset returns the parser to the start of a string and empties both registers.
// Only a word that ends a string waits on a stalled output; others pass freely.
module decimal_string_parser #(
    parameter int VALUE_BITS = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    output logic                char_stall,
    input  logic [7:0]          char_code,
    input  logic                last_char,
    input  logic                empty_string,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [2:0]          status,
    output logic                negative,
    output logic [62:0]         magnitude_high,
    output logic [63:0]         magnitude_low,
    output logic [7:0]          fraction_count,
    output logic signed [31:0]  exponent_value
);

    logic              s1_valid_reg;
    logic [7:0]        s1_char_reg;
    logic              s1_last_reg;
    logic              s1_empty_reg;
    logic              out_valid_reg;
    dsp_pkg::result_t  out_reg;

    logic              produce;
    logic              blocked;
    logic              step;
    dsp_pkg::result_t  core_result;

    assign blocked    = s1_valid_reg && produce && out_valid_reg && result_stall;
    assign step       = s1_valid_reg && !blocked;
    assign char_stall = blocked;

    dsp_core #(
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .char_code    (s1_char_reg),
        .last_char    (s1_last_reg),
        .empty_string (s1_empty_reg),
        .produce      (produce),
        .result       (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (char_valid && !char_stall)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (step && produce)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            s1_char_reg  <= char_code;
            s1_last_reg  <= last_char;
            s1_empty_reg <= empty_string;
        end
        if (step && produce)
        begin
            out_reg <= core_result;
        end
    end

    assign result_valid   = out_valid_reg;
    assign status         = out_reg.status;
    assign negative       = out_reg.negative;
    assign magnitude_high = out_reg.magnitude[126:64];
    assign magnitude_low  = out_reg.magnitude[63:0];
    assign fraction_count = out_reg.fraction_count;
    assign exponent_value = out_reg.exponent_value;

endmodule
